// ===== rtl/ps2mt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, codes and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  // Default cursor coordinate width.
  localparam int COORD_BITS_DEFAULT = 12;

  // Widths fixed by the register map and the mouse protocol.
  localparam int SIZE_BITS  = 13;
  localparam int DELTA_BITS = 8;
  localparam int BYTE_BITS  = 8;
  localparam int BTN_BITS   = 3;
  localparam int CFG_IDX_BITS = 2;

  // Header byte fields.
  localparam logic [BYTE_BITS-1:0] SYNC_MASK = 8'h08;
  localparam logic [BYTE_BITS-1:0] OVF_MASK  = 8'hC0;
  localparam logic [BYTE_BITS-1:0] BTN_MASK  = 8'h07;

  // Reset values of the configuration and the cursor.
  localparam logic [SIZE_BITS-1:0]  SCREEN_WIDTH_RESET  = 13'd320;
  localparam logic [SIZE_BITS-1:0]  SCREEN_HEIGHT_RESET = 13'd200;
  localparam logic [DELTA_BITS-1:0] MAX_DELTA_RESET     = 8'd55;
  localparam int POS_X_RESET = 160;
  localparam int POS_Y_RESET = 100;

  // Depth of the packet queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_MAX_DELTA     = 2'd2
  } reg_idx_e;

  // Packet status codes.
  typedef enum logic [1:0] {
    STATUS_ACCEPTED     = 2'd0,
    STATUS_SYNC_MISSING = 2'd1,
    STATUS_OVERFLOW     = 2'd2
  } status_e;

  // Position of the next byte within a packet.
  typedef enum logic [2:0] {
    BYTE_HEADER = 3'b001,
    BYTE_X      = 3'b010,
    BYTE_Y      = 3'b100
  } byte_pos_e;

  // One complete packet as handed from the front to the back.
  typedef struct packed {
    logic [BYTE_BITS-1:0] header;
    logic [BYTE_BITS-1:0] x_delta;
    logic [BYTE_BITS-1:0] y_delta;
  } packet_t;

endpackage

// ===== rtl/ps2mt_fifo.sv =====
// ----------------------------------------------------------------------------
// ps2mt_fifo
// Small register queue with first-word fall-through output.
// ----------------------------------------------------------------------------
module ps2mt_fifo #(
  parameter int Width = 24,
  parameter int Depth = ps2mt_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] head_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/ps2mt_front.sv =====
// ----------------------------------------------------------------------------
// ps2mt_front
// Collects received bytes into three-byte packets and queues them.
// ----------------------------------------------------------------------------
module ps2mt_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ps2mt_pkg::BYTE_BITS-1:0]      rx_byte_i,
  output logic                                 push_o,
  output ps2mt_pkg::packet_t                   packet_o,
  input  logic                                 full_i
);

  ps2mt_pkg::byte_pos_e state_q, state_d;
  logic [ps2mt_pkg::BYTE_BITS-1:0] header_q;
  logic [ps2mt_pkg::BYTE_BITS-1:0] x_delta_q;
  logic accept;

  // Only the closing byte of a packet needs room in the queue.
  assign in_ready_o = !((state_q == ps2mt_pkg::BYTE_Y) && full_i);
  assign accept     = in_valid_i && in_ready_o;

  assign push_o           = accept && (state_q == ps2mt_pkg::BYTE_Y);
  assign packet_o.header  = header_q;
  assign packet_o.x_delta = x_delta_q;
  assign packet_o.y_delta = rx_byte_i;

  always_comb begin
    state_d = state_q;
    if (accept) begin
      unique case (state_q)
        ps2mt_pkg::BYTE_HEADER: state_d = ps2mt_pkg::BYTE_X;
        ps2mt_pkg::BYTE_X:      state_d = ps2mt_pkg::BYTE_Y;
        ps2mt_pkg::BYTE_Y:      state_d = ps2mt_pkg::BYTE_HEADER;
        default:                state_d = ps2mt_pkg::BYTE_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2mt_pkg::BYTE_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (state_q == ps2mt_pkg::BYTE_HEADER)) begin
      header_q <= rx_byte_i;
    end
    if (accept && (state_q == ps2mt_pkg::BYTE_X)) begin
      x_delta_q <= rx_byte_i;
    end
  end

endmodule

// ===== rtl/ps2mt_back.sv =====
// ----------------------------------------------------------------------------
// ps2mt_back
// Checks each queued packet, moves the cursor and registers the result.
// ----------------------------------------------------------------------------
module ps2mt_back #(
  parameter int CoordBits = ps2mt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  ps2mt_pkg::packet_t                   head_i,
  output logic                                 pop_o,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0]      screen_width_i,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0]      screen_height_i,
  input  logic [ps2mt_pkg::DELTA_BITS-1:0]     max_delta_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           packet_status_o,
  output logic [CoordBits-1:0]                 cursor_x_o,
  output logic [CoordBits-1:0]                 cursor_y_o,
  output logic [ps2mt_pkg::BTN_BITS-1:0]       button_state_o
);

  // Working width for position arithmetic: holds the coordinate, the screen
  // bound and the delta, plus a sign bit.
  localparam int SumBits = ((CoordBits > ps2mt_pkg::SIZE_BITS) ?
                            CoordBits : ps2mt_pkg::SIZE_BITS) + 2;
  localparam int DBits = 10;

  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [ps2mt_pkg::BTN_BITS-1:0] buttons_q, buttons_d;
  logic out_valid_q;
  ps2mt_pkg::status_e status_q, status_d;
  logic [CoordBits-1:0] out_x_q, out_y_q;
  logic [ps2mt_pkg::BTN_BITS-1:0] out_btn_q;

  logic signed [DBits-1:0] m_pos, m_neg, dx_raw, dy_raw, dx, dy;
  logic [ps2mt_pkg::SIZE_BITS-1:0] w_m1, h_m1;
  logic [SumBits-1:0] mask_w, lim_x, lim_y;
  logic signed [SumBits-1:0] sum_x, sum_y;
  logic [CoordBits-1:0] new_x, new_y;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // Clamp both deltas to the configured magnitude.
  assign m_pos  = signed'({2'b00, max_delta_i});
  assign m_neg  = -m_pos;
  assign dx_raw = signed'({{2{head_i.x_delta[7]}}, head_i.x_delta});
  assign dy_raw = signed'({{2{head_i.y_delta[7]}}, head_i.y_delta});

  always_comb begin
    if (dx_raw > m_pos) begin
      dx = m_pos;
    end else if (dx_raw < m_neg) begin
      dx = m_neg;
    end else begin
      dx = dx_raw;
    end
    if (dy_raw > m_pos) begin
      dy = m_pos;
    end else if (dy_raw < m_neg) begin
      dy = m_neg;
    end else begin
      dy = dy_raw;
    end
  end

  // Screen bounds: size minus one, zero for an empty screen, and never past
  // the largest coordinate.
  assign w_m1   = (screen_width_i == '0) ? '0 : screen_width_i - 1'b1;
  assign h_m1   = (screen_height_i == '0) ? '0 : screen_height_i - 1'b1;
  assign mask_w = SumBits'({CoordBits{1'b1}});
  assign lim_x  = (SumBits'(w_m1) > mask_w) ? mask_w : SumBits'(w_m1);
  assign lim_y  = (SumBits'(h_m1) > mask_w) ? mask_w : SumBits'(h_m1);

  // Y is inverted: moving the mouse up lowers the row number.
  assign sum_x = signed'(SumBits'(pos_x_q)) +
                 signed'({{(SumBits-DBits){dx[DBits-1]}}, dx});
  assign sum_y = signed'(SumBits'(pos_y_q)) -
                 signed'({{(SumBits-DBits){dy[DBits-1]}}, dy});

  always_comb begin
    if (sum_x[SumBits-1]) begin
      new_x = '0;
    end else if (unsigned'(sum_x) > lim_x) begin
      new_x = lim_x[CoordBits-1:0];
    end else begin
      new_x = sum_x[CoordBits-1:0];
    end
    if (sum_y[SumBits-1]) begin
      new_y = '0;
    end else if (unsigned'(sum_y) > lim_y) begin
      new_y = lim_y[CoordBits-1:0];
    end else begin
      new_y = sum_y[CoordBits-1:0];
    end
  end

  // A missing sync bit takes precedence over an overflow.
  always_comb begin
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    buttons_d = buttons_q;
    priority if ((head_i.header & ps2mt_pkg::SYNC_MASK) == '0) begin
      status_d = ps2mt_pkg::STATUS_SYNC_MISSING;
    end else if ((head_i.header & ps2mt_pkg::OVF_MASK) != '0) begin
      status_d = ps2mt_pkg::STATUS_OVERFLOW;
    end else begin
      status_d  = ps2mt_pkg::STATUS_ACCEPTED;
      pos_x_d   = new_x;
      pos_y_d   = new_y;
      buttons_d = head_i.header[ps2mt_pkg::BTN_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= CoordBits'(ps2mt_pkg::POS_X_RESET);
      pos_y_q     <= CoordBits'(ps2mt_pkg::POS_Y_RESET);
      buttons_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        buttons_q   <= buttons_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      out_x_q   <= pos_x_d;
      out_y_q   <= pos_y_d;
      out_btn_q <= buttons_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_status_o = status_q;
  assign cursor_x_o      = out_x_q;
  assign cursor_y_o      = out_y_q;
  assign button_state_o  = out_btn_q;

endmodule

// ===== rtl/ps2_mouse_packet_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Three-byte PS/2 mouse packet decoder with a saturating cursor tracker.
// ----------------------------------------------------------------------------
// Each item on the input channel is one byte received from the mouse. Bytes
// are grouped into packets of three: header, X delta and Y delta. The first
// two bytes of a packet give no result; the third one gives exactly one
// result item carrying a status, the cursor position and the button state.
// A header without its always-one sync bit is reported as sync missing, and
// one with an overflow bit is reported as overflow (sync missing wins when
// both apply); such a packet leaves cursor and buttons as they were. A good
// packet loads the buttons, clamps both signed deltas to +/- max_delta and
// moves the cursor right by X and up by Y (the row number falls), saturating
// at zero and at the screen size minus one. The block takes one byte per
// clock cycle while the queue has room for a packet's third byte. A packet
// travels from the byte collector through a two-entry queue into the update
// stage, whose combinational clamp, add and saturate allow one packet per
// cycle while the consumer takes each result. The packet is pushed into the
// queue when its third byte is accepted, and is popped from the queue into
// the output register, which presents the result, once the output is free.
// While the output waits to be taken the collector keeps accepting bytes until
// the queue is full and a third byte waits. Configuration writes take effect
// at once and are always accepted; change the registers only while no packet
// is in flight. Register indexes: 0 screen width, 1 screen height, 2 max
// delta; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Byte input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [ps2mt_pkg::BYTE_BITS-1:0]       rx_byte_i,
  // Result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            packet_status_o,
  output logic [COORD_BITS-1:0]                 cursor_x_o,
  output logic [COORD_BITS-1:0]                 cursor_y_o,
  output logic [ps2mt_pkg::BTN_BITS-1:0]        button_state_o,
  // Configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ps2mt_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0]       cfg_data_i
);

  localparam int PktBits = $bits(ps2mt_pkg::packet_t);

  logic [ps2mt_pkg::SIZE_BITS-1:0]  screen_width_q;
  logic [ps2mt_pkg::SIZE_BITS-1:0]  screen_height_q;
  logic [ps2mt_pkg::DELTA_BITS-1:0] max_delta_q;

  logic               push, full, pop, empty;
  ps2mt_pkg::packet_t push_pkt, head_pkt;
  logic [PktBits-1:0] head_bits;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ps2mt_pkg::SCREEN_WIDTH_RESET;
      screen_height_q <= ps2mt_pkg::SCREEN_HEIGHT_RESET;
      max_delta_q     <= ps2mt_pkg::MAX_DELTA_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ps2mt_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        ps2mt_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        ps2mt_pkg::REG_MAX_DELTA:
          max_delta_q <= cfg_data_i[ps2mt_pkg::DELTA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Byte collector: tracks the position within a packet and queues each
  // completed packet.
  ps2mt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .packet_o   (push_pkt),
    .full_i     (full)
  );

  // Packet queue decoupling the collector from the update stage.
  ps2mt_fifo #(
    .Width (PktBits),
    .Depth (ps2mt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pkt),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_bits)
  );

  assign head_pkt = ps2mt_pkg::packet_t'(head_bits);

  // Update stage: validates the header, moves the cursor and holds the
  // result until the consumer takes it.
  ps2mt_back #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head_pkt),
    .pop_o           (pop),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .max_delta_i     (max_delta_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .packet_status_o (packet_status_o),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .button_state_o  (button_state_o)
  );

endmodule
